### sv/gds_pkg.sv
// shared types and constants for the greedy dominating set core
package gds_pkg;

  localparam int unsigned GDS_MAX_VERTICES = 64;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    MEM_IDLE,
    MEM_CLEAR,
    MEM_RD_A,
    MEM_WR_A_RD_B,
    MEM_WR_B,
    MEM_SCAN
  } gds_mem_op_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] vertex_a;
    logic [5:0] vertex_b;
  } gds_req_t;

  typedef struct packed {
    logic [5:0] sel_vertex;
    logic       has_vertex;
    logic [6:0] set_size;
    logic       last;
  } gds_res_t;

  typedef struct packed {
    gds_mem_op_e mem_op;
    logic        capture;
    logic        mask_clr;
    logic        round_init;
    logic        commit;
    logic        emit_empty;
  } gds_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       edge_ok;
    logic       sweep_last;
    logic       open;
    logic       scan_last;
    logic       pipe_empty;
    logic       done;
  } gds_sts_t;

endpackage

### sv/gds_datapath.sv
// datapath: adjacency memory, scan pipeline, masks and result register
module gds_datapath import gds_pkg::*; #(
  parameter int unsigned MAX_VERTICES = GDS_MAX_VERTICES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  gds_req_t   req_i,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_data_i,
  input  gds_cmd_t   cmd_i,
  output gds_sts_t   sts_o,
  output logic       res_valid_o,
  output gds_res_t   res_o
);

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  typedef logic [MAX_VERTICES-1:0] row_t;

  row_t          mem_q [MAX_VERTICES];
  row_t          rd_q;
  logic [6:0]    cfg_q;
  gds_req_t      req_q;
  logic [VW-1:0] sweep_q;
  logic [VW-1:0] scan_q;
  logic          s1_valid_q;
  logic [VW-1:0] s1_idx_q;
  logic          s2_valid_q;
  logic [VW-1:0] s2_idx_q;
  logic          s2_chosen_q;
  row_t          closed_q;
  row_t          dom_q;
  row_t          chosen_q;
  logic [CW-1:0] total_q;
  logic [CW-1:0] best_gain_q;
  logic [VW-1:0] best_idx_q;
  row_t          best_closed_q;
  logic          res_valid_q;
  gds_res_t      res_q;

  logic [CW-1:0] n;
  row_t          valid_mask;
  logic [VW-1:0] a_idx;
  logic [VW-1:0] b_idx;
  logic          mem_we;
  logic [VW-1:0] wr_addr;
  row_t          wr_data;
  logic          rd_en;
  logic [VW-1:0] rd_addr;
  row_t          open_bits;
  logic [CW-1:0] gain;
  row_t          dom_next;
  logic          done;
  logic          take_best;

  always_comb begin
    if (32'(cfg_q) > MAX_VERTICES) begin
      n = CW'(MAX_VERTICES);
    end else begin
      n = CW'(cfg_q);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      valid_mask[i] = (i < 32'(n));
    end
  end

  assign a_idx = VW'(req_q.vertex_a);
  assign b_idx = VW'(req_q.vertex_b);

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = sweep_q;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = scan_q;
    unique case (cmd_i.mem_op)
      MEM_IDLE: begin
      end
      MEM_CLEAR: begin
        mem_we = 1'b1;
      end
      MEM_RD_A: begin
        rd_en   = 1'b1;
        rd_addr = a_idx;
      end
      MEM_WR_A_RD_B: begin
        mem_we  = 1'b1;
        wr_addr = a_idx;
        wr_data = rd_q | (row_t'(1) << req_q.vertex_b);
        rd_en   = 1'b1;
        rd_addr = b_idx;
      end
      MEM_WR_B: begin
        mem_we  = 1'b1;
        wr_addr = b_idx;
        wr_data = rd_q | (row_t'(1) << req_q.vertex_a);
      end
      MEM_SCAN: begin
        rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // gain of the candidate in the last scan stage
  always_comb begin
    open_bits = closed_q & ~dom_q;
    gain      = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      gain = gain + CW'(open_bits[i]);
    end
  end

  assign take_best = s2_valid_q && !s2_chosen_q && (gain > best_gain_q);
  assign dom_next  = dom_q | best_closed_q;
  assign done      = ((valid_mask & ~dom_next) == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q         <= '0;
      sweep_q       <= '0;
      scan_q        <= '0;
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      dom_q         <= '0;
      chosen_q      <= '0;
      total_q       <= '0;
      best_gain_q   <= '0;
      best_idx_q    <= '0;
      best_closed_q <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      if (cmd_i.mem_op == MEM_CLEAR) begin
        sweep_q <= sts_o.sweep_last ? '0 : sweep_q + VW'(1);
      end
      if (cmd_i.round_init) begin
        scan_q <= '0;
      end else if (cmd_i.mem_op == MEM_SCAN) begin
        scan_q <= scan_q + VW'(1);
      end
      s1_valid_q <= (cmd_i.mem_op == MEM_SCAN);
      s2_valid_q <= s1_valid_q;
      if (cmd_i.round_init) begin
        best_gain_q   <= '0;
        best_idx_q    <= '0;
        best_closed_q <= '0;
      end else if (take_best) begin
        best_gain_q   <= gain;
        best_idx_q    <= s2_idx_q;
        best_closed_q <= closed_q;
      end
      if (cmd_i.mask_clr) begin
        dom_q    <= '0;
        chosen_q <= '0;
        total_q  <= '0;
      end else if (cmd_i.commit) begin
        dom_q    <= dom_next;
        chosen_q <= chosen_q | (row_t'(1) << best_idx_q);
        total_q  <= total_q + CW'(1);
      end
      res_valid_q <= cmd_i.commit | cmd_i.emit_empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.mem_op == MEM_SCAN) begin
      s1_idx_q <= scan_q;
    end
    if (s1_valid_q) begin
      s2_idx_q    <= s1_idx_q;
      s2_chosen_q <= chosen_q[s1_idx_q];
      closed_q    <= (rd_q | (row_t'(1) << s1_idx_q)) & valid_mask;
    end
    if (cmd_i.commit) begin
      res_q.sel_vertex <= 6'(best_idx_q);
      res_q.has_vertex <= 1'b1;
      res_q.set_size   <= 7'(total_q + CW'(1));
      res_q.last       <= done;
    end else if (cmd_i.emit_empty) begin
      res_q.sel_vertex <= '0;
      res_q.has_vertex <= 1'b0;
      res_q.set_size   <= '0;
      res_q.last       <= 1'b1;
    end
  end

  assign sts_o.req_type   = req_q.req_type;
  assign sts_o.edge_ok    = (req_q.vertex_a != req_q.vertex_b)
                            && (32'(req_q.vertex_a) < MAX_VERTICES)
                            && (32'(req_q.vertex_b) < MAX_VERTICES);
  assign sts_o.sweep_last = (sweep_q == VW'(MAX_VERTICES - 1));
  assign sts_o.open       = |(valid_mask & ~dom_q);
  assign sts_o.scan_last  = (CW'(scan_q) == (n - CW'(1)));
  assign sts_o.pipe_empty = !s1_valid_q && !s2_valid_q;
  assign sts_o.done       = done;

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### sv/gds_ctrl.sv
// controller state machine sequencing edge loads, clears and greedy rounds
module gds_ctrl import gds_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  gds_sts_t sts_i,
  output gds_cmd_t cmd_o,
  output logic     busy_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ADD_A,
    S_ADD_B,
    S_ADD_W,
    S_RUN_CHECK,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.mem_op     = MEM_IDLE;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.mem_op = MEM_CLEAR;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.req_type)
          REQ_ADD: begin
            state_d = sts_i.edge_ok ? S_ADD_A : S_IDLE;
          end
          REQ_RUN: begin
            cmd_o.mask_clr = 1'b1;
            state_d        = S_RUN_CHECK;
          end
          REQ_CLEAR: begin
            cmd_o.mask_clr = 1'b1;
            state_d        = S_CLEAR;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_ADD_A: begin
        cmd_o.mem_op = MEM_RD_A;
        state_d      = S_ADD_B;
      end
      S_ADD_B: begin
        cmd_o.mem_op = MEM_WR_A_RD_B;
        state_d      = S_ADD_W;
      end
      S_ADD_W: begin
        cmd_o.mem_op = MEM_WR_B;
        state_d      = S_IDLE;
      end
      S_RUN_CHECK: begin
        if (sts_i.open) begin
          cmd_o.round_init = 1'b1;
          state_d          = S_SCAN;
        end else begin
          cmd_o.emit_empty = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.mem_op = MEM_SCAN;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts_i.pipe_empty) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        if (sts_i.done) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.round_init = 1'b1;
          state_d          = S_SCAN;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### sv/greedy_dominating_set_core.sv
// greedy dominating set core: edge loading, graph clear and greedy selection runs
// after reset the adjacency memory is swept to zero, with busy high
// add edge: both rows updated, unless ignored; clear: memory sweep; neither gives a result
// run: decode and check, then per round a scan of n rows, a pipeline drain and a commit;
// each round's result strobed the cycle after commit; n = 0 gives one empty result
// results are strobed for one cycle and cannot be stalled
module greedy_dominating_set_core import gds_pkg::*; #(
  parameter int unsigned MAX_VERTICES = GDS_MAX_VERTICES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  gds_req_t   req_i,
  output logic       res_valid_o,
  output gds_res_t   res_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i
);

  gds_cmd_t cmd;
  gds_sts_t sts;

  assign cfg_ready_o = ~busy;

  gds_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  gds_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

### verif/gds_selection_checker.sv
// checker for the greedy dominating set core: tracks the graph, predicts and compares
module gds_selection_checker import gds_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_i,
  input  gds_req_t   req_i,
  input  logic       res_valid_i,
  input  gds_res_t   res_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [6:0] cfg_data_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0] neighbor_rows [GDS_MAX_VERTICES];
  logic [6:0]  count_setting;
  gds_res_t    expected_picks [$];
  gds_res_t    want;
  int          mismatches;

  function automatic void predict_selection();
    logic [63:0] in_use;
    logic [63:0] dominated;
    logic [63:0] chosen;
    logic [63:0] closed;
    int unsigned n;
    int unsigned best;
    int unsigned best_gain;
    int unsigned gain;
    int unsigned total;
    gds_res_t    pick;
    n = (count_setting > GDS_MAX_VERTICES) ? GDS_MAX_VERTICES : count_setting;
    in_use = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    dominated = '0;
    chosen = '0;
    total = 0;
    while ((in_use & ~dominated) != '0) begin
      best = 0;
      best_gain = 0;
      for (int v = 0; v < n; v++) begin
        if (!chosen[v]) begin
          closed = neighbor_rows[v] | (64'd1 << v);
          gain = $countones(closed & in_use & ~dominated);
          if (gain > best_gain) begin
            best_gain = gain;
            best = v;
          end
        end
      end
      if (best_gain == 0) break;
      chosen[best] = 1'b1;
      dominated |= (neighbor_rows[best] | (64'd1 << best)) & in_use;
      total++;
      pick.sel_vertex = 6'(best);
      pick.has_vertex = 1'b1;
      pick.set_size = 7'(total);
      pick.last = 1'b0;
      expected_picks.push_back(pick);
    end
    if (total == 0) begin
      pick = '0;
      pick.last = 1'b1;
      expected_picks.push_back(pick);
    end else begin
      pick = expected_picks.pop_back();
      pick.last = 1'b1;
      expected_picks.push_back(pick);
    end
  endfunction

  function automatic void check_field(input string field, input logic [6:0] exp_val,
                                      input logic [6:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", field, exp_val, got_val);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < GDS_MAX_VERTICES; v++) neighbor_rows[v] = '0;
      count_setting = '0;
      expected_picks.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) count_setting = cfg_data_i;
      if (res_valid_i) begin
        if (expected_picks.size() == 0) begin
          $error("result with none expected: sel_vertex %0d, set_size %0d",
                 res_i.sel_vertex, res_i.set_size);
          mismatches++;
        end else begin
          want = expected_picks.pop_front();
          check_field("sel_vertex", 7'(want.sel_vertex), 7'(res_i.sel_vertex));
          check_field("has_vertex", 7'(want.has_vertex), 7'(res_i.has_vertex));
          check_field("set_size", want.set_size, res_i.set_size);
          check_field("last", 7'(want.last), 7'(res_i.last));
        end
      end
      if (start_i && !busy_i) begin
        case (req_i.req_type)
          REQ_ADD: begin
            if (req_i.vertex_a != req_i.vertex_b) begin
              neighbor_rows[req_i.vertex_a][req_i.vertex_b] = 1'b1;
              neighbor_rows[req_i.vertex_b][req_i.vertex_a] = 1'b1;
            end
          end
          REQ_RUN: begin
            predict_selection();
          end
          REQ_CLEAR: begin
            for (int v = 0; v < GDS_MAX_VERTICES; v++) neighbor_rows[v] = '0;
          end
          default: ;
        endcase
      end
      fail_count_o <= mismatches;
      pending_o <= expected_picks.size();
    end
  end

endmodule

### verif/greedy_dominating_set_core_tb.sv
// testbench top for the greedy dominating set core: stimulus, pacing, watchdog and verdict
module greedy_dominating_set_core_tb import gds_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 80;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES = 7;
  localparam int ITEMS_PER_PHASE = 20;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  gds_req_t   req = '0;
  logic       res_valid;
  gds_res_t   res;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = '0;
  int         fail_count;
  int         pending;

  int quiet_cycles;
  int burst_left;
  int cur_vertices;
  int runs_sent;
  int adds_sent;
  int clears_sent;
  int unused_sent;
  int settings_written;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  greedy_dominating_set_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_o       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  gds_selection_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // one request transfer, then the sender's burst and gap pacing
  task automatic send_req(input logic [1:0] kind, input logic [5:0] a, input logic [5:0] b);
    start <= 1'b1;
    req <= '{req_type: kind, vertex_a: a, vertex_b: b};
    @(posedge clk);
    while (busy) @(posedge clk);
    case (kind)
      REQ_ADD:   adds_sent++;
      REQ_RUN:   runs_sent++;
      REQ_CLEAR: clears_sent++;
      default:   unused_sent++;
    endcase
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 6);
    end
  endtask

  // hold off until every predicted pick has arrived and the core has settled
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_vertices = (value > GDS_MAX_VERTICES) ? GDS_MAX_VERTICES : value;
    settings_written++;
  endtask

  // mostly endpoints among the vertices in use, sometimes anywhere
  function automatic logic [5:0] pick_vertex();
    if (cur_vertices > 0 && $urandom_range(0, 9) != 0)
      return 6'($urandom_range(0, cur_vertices - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((start && !busy) || res_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** greedy_dominating_set_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int roll;
    logic [6:0] phase_count;
    burst_left = 0;
    cur_vertices = 0;
    runs_sent = 0;
    adds_sent = 0;
    clears_sent = 0;
    unused_sent = 0;
    settings_written = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty graph straight out of reset
    send_req(REQ_RUN, 6'd0, 6'd0);
    drain();
    write_vertex_count(7'd5);
    send_req(REQ_RUN, 6'd63, 6'd63);
    // self-loop, duplicate, endpoint beyond the count, unused request
    send_req(REQ_ADD, 6'd0, 6'd1);
    send_req(REQ_ADD, 6'd1, 6'd2);
    send_req(REQ_ADD, 6'd3, 6'd3);
    send_req(REQ_ADD, 6'd2, 6'd1);
    send_req(REQ_ADD, 6'd63, 6'd0);
    send_req(REQ_UNUSED, 6'd63, 6'd63);
    send_req(REQ_RUN, 6'd0, 6'd0);
    drain();
    // count above the maximum saturates, hidden edge becomes visible
    write_vertex_count(7'd127);
    send_req(REQ_RUN, 6'd21, 6'd42);
    send_req(REQ_CLEAR, 6'd0, 6'd0);
    send_req(REQ_RUN, 6'd0, 6'd0);
    send_req(REQ_ADD, 6'd42, 6'd21);
    send_req(REQ_ADD, 6'd63, 6'd62);
    send_req(REQ_RUN, 6'd0, 6'd0);
    drain();
    write_vertex_count(7'd1);
    send_req(REQ_RUN, 6'd0, 6'd0);
    send_req(REQ_ADD, 6'd0, 6'd1);
    send_req(REQ_RUN, 6'd0, 6'd0);
    drain();
    write_vertex_count(7'd64);
    send_req(REQ_CLEAR, 6'd63, 6'd63);
    send_req(REQ_RUN, 6'd0, 6'd0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       phase_count = 7'($urandom_range(2, 12));
        1:       phase_count = 7'd64;
        2:       phase_count = 7'd0;
        4:       phase_count = 7'd127;
        5:       phase_count = 7'($urandom_range(0, 127));
        default: phase_count = 7'($urandom_range(1, 20));
      endcase
      write_vertex_count(phase_count);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          send_req(REQ_ADD, pick_vertex(), pick_vertex());
        end else if (roll < 86) begin
          send_req(REQ_RUN, 6'($urandom), 6'($urandom));
        end else if (roll < 90) begin
          send_req(REQ_CLEAR, 6'($urandom), 6'($urandom));
        end else if (roll < 94) begin
          send_req(REQ_UNUSED, 6'($urandom), 6'($urandom));
        end else begin
          send_req(REQ_RUN, 6'($urandom), 6'($urandom));
          drain();
        end
      end
      send_req(REQ_RUN, 6'($urandom), 6'($urandom));
      drain();
    end

    $display("covered %0d requests: %0d runs, %0d edge adds, %0d clears, %0d unused",
             runs_sent + adds_sent + clears_sent + unused_sent,
             runs_sent, adds_sent, clears_sent, unused_sent);
    $display("across %0d vertex count settings, from empty to saturated",
             settings_written);
    if (fail_count == 0) begin
      $display("** greedy_dominating_set_core: PASSED **");
    end else begin
      $display("** greedy_dominating_set_core: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
sv/gds_pkg.sv
sv/gds_datapath.sv
sv/gds_ctrl.sv
sv/greedy_dominating_set_core.sv
verif/gds_selection_checker.sv
verif/greedy_dominating_set_core_tb.sv
